// ===== design/spiral_bucket_order_macros.svh =====
// assertion macros used by the spiral bucket order checker
`ifndef SPIRAL_BUCKET_ORDER_MACROS_SVH
`define SPIRAL_BUCKET_ORDER_MACROS_SVH

// property must hold at every clock edge outside reset
`define SBO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define SBO_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/sbo_pkg.sv =====
// types, constants and helpers of the spiral bucket order block
`default_nettype none

package sbo_pkg;

  localparam int MAX_TILES_PER_SIDE = 256;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int INDEX_W   = 17;
  localparam int COORD_W   = 10;
  localparam int SIDE_W    = $clog2(MAX_TILES_PER_SIDE + 1);
  localparam int AREA_W    = $clog2(MAX_TILES_PER_SIDE * MAX_TILES_PER_SIDE + 1);
  localparam int CMP_W     = ((AREA_W > INDEX_W) ? AREA_W : INDEX_W) + 1;

  typedef logic [CFG_W-1:0]          cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [SIDE_W-1:0]         side_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [AREA_W-1:0]         area_t;
  typedef logic [CMP_W-1:0]          wide_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILES_ACROSS = 1'b0,
    CFG_TILES_DOWN   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_EDGE,
    S_OUT
  } state_t;

  // register value saturated to the largest supported side
  function automatic side_t clamp_side(input cfg_data_t v);
    if (int'(v) > MAX_TILES_PER_SIDE) begin
      return side_t'(MAX_TILES_PER_SIDE);
    end
    return side_t'(v);
  endfunction

endpackage

`default_nettype wire

// ===== design/sbo_if.sv =====
// request, result and register write channels of the spiral bucket order block
`default_nettype none

interface sbo_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface sbo_res_if
  import sbo_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t tile_x;
  coord_t tile_y;
  logic   valid_res;
  modport source (output valid, output tile_x, output tile_y, output valid_res, input ready);
  modport sink (input valid, input tile_x, input tile_y, input valid_res, output ready);
endinterface

interface sbo_cfg_if
  import sbo_pkg::*;
();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/spiral_bucket_order.sv =====
// Spiral tile order generator: each request beat returns the next tile of a
// tiles_across by tiles_down grid (the first one on restart), walked from the
// centre outward, and, when a tile is found, advances the visit counter; once
// the grid is used up it answers valid_res = 0 with zero coordinates. Each
// request peels rings off the grid until the inner area no longer covers the
// index; the number of rings peeled is at most the smaller side, and it is
// largest for the centre tile. A single subtract unit shrinks the ring area by
// one ring per cycle, from w*h to (w-1)*(h-1). A request on a used-up grid goes
// from the check state straight to the output state. The request side is not
// ready while an item is in work or its result is held, and the next request is
// taken in the cycle after the result beat. Register writes are taken at any
// time and must only be issued while the block is idle.
`default_nettype none

module spiral_bucket_order
  import sbo_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  sbo_cfg_if.sink   cfg,
  sbo_req_if.sink   req,
  sbo_res_if.source res
);

  state_t    state, state_next;
  cfg_data_t tiles_across, tiles_down;
  index_t    visit_index;

  index_t    n;
  side_t     w, h;
  area_t     area;
  coord_t    tile_x, tile_y;
  logic      valid_res;

  side_t                across_c, down_c, smaller_c, m_c, half_s, centre_s;
  logic [2*SIDE_W-1:0]  prod;
  wide_t                n_w, area_w, w_w, h_w, area_dec, d_w, dh_w;
  logic                 more, bottom, odd_ring;
  logic [COORD_W-1:0]   d_c, dh_c, w_c, h_c, half_c, centre_c, x_c, y_c;

  // grid sides as used, and the full grid area for the first ring
  assign across_c  = clamp_side(tiles_across);
  assign down_c    = clamp_side(tiles_down);
  assign smaller_c = (across_c < down_c) ? across_c : down_c;
  assign prod      = across_c * down_c;

  // shared ring unit: compare index against area, step to the next inner ring
  assign n_w      = wide_t'(n);
  assign area_w   = wide_t'(area);
  assign w_w      = wide_t'(w);
  assign h_w      = wide_t'(h);
  assign more     = n_w < area_w;
  assign area_dec = area_w - w_w - h_w + wide_t'(1);

  // edge formulas on the found ring, kept modulo the coordinate width
  assign m_c      = (w < h) ? w : h;
  assign half_s   = m_c >> 1;
  assign odd_ring = m_c[0];
  assign centre_s = (smaller_c - side_t'(1)) >> 1;
  assign d_w      = n_w - area_w;
  assign dh_w     = n_w - area_w - h_w;
  assign bottom   = n_w > (area_w + h_w);
  assign d_c      = d_w[COORD_W-1:0];
  assign dh_c     = dh_w[COORD_W-1:0];
  assign w_c      = COORD_W'(w);
  assign h_c      = COORD_W'(h);
  assign half_c   = COORD_W'(half_s);
  assign centre_c = COORD_W'(centre_s);

  always_comb begin
    if (odd_ring) begin
      if (!bottom) begin
        x_c = w_c - half_c;
        y_c = d_c - half_c;
      end else begin
        x_c = w_c - half_c - dh_c;
        y_c = h_c - half_c;
      end
    end else begin
      if (!bottom) begin
        x_c = '0 - half_c;
        y_c = h_c - half_c - d_c;
      end else begin
        x_c = dh_c - half_c;
        y_c = '0 - half_c;
      end
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req.valid) state_next = S_CHECK;
      S_CHECK:  state_next = more ? S_SEARCH : S_OUT;
      S_SEARCH: if (!more) state_next = S_EDGE;
      S_EDGE:   state_next = S_OUT;
      S_OUT:    if (res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cfg.ready     = 1'b1;
    req.ready     = (state == S_IDLE);
    res.valid     = (state == S_OUT);
    res.tile_x    = tile_x;
    res.tile_y    = tile_y;
    res.valid_res = valid_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tiles_across <= cfg_data_t'(1);
      tiles_down   <= cfg_data_t'(1);
      visit_index  <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          CFG_TILES_ACROSS: tiles_across <= cfg.data;
          CFG_TILES_DOWN:   tiles_down   <= cfg.data;
          default: ;
        endcase
      end
      if (state == S_IDLE && req.valid && req.restart) begin
        visit_index <= '0;
      end else if (state == S_EDGE) begin
        visit_index <= n + index_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          n    <= req.restart ? '0 : visit_index;
          w    <= across_c;
          h    <= down_c;
          area <= prod[AREA_W-1:0];
        end
      end
      S_CHECK: begin
        // grid used up
        if (!more) begin
          tile_x    <= '0;
          tile_y    <= '0;
          valid_res <= 1'b0;
        end
      end
      S_SEARCH: begin
        if (more) begin
          area <= area_dec[AREA_W-1:0];
          w    <= w - side_t'(1);
          h    <= h - side_t'(1);
        end
      end
      S_EDGE: begin
        tile_x    <= coord_t'(x_c + centre_c);
        tile_y    <= coord_t'(y_c + centre_c);
        valid_res <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sbo_checker.sv =====
// port-level checks of the spiral bucket order block and their bind
`default_nettype none

`include "spiral_bucket_order_macros.svh"

module sbo_checker
  import sbo_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   req_valid,
  input logic   req_ready,
  input logic   res_valid,
  input logic   res_ready,
  input logic   valid_res,
  input coord_t tile_x,
  input coord_t tile_y
);

  // one item in work at a time
  `SBO_NEVER(a_no_overlap, req_ready && res_valid, "request ready while a result is held")

  // a request beat starts work, nothing is shown in the next cycle
  `SBO_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready && !res_valid, "no busy cycle after request beat")

  // exhausted grid answers zero coordinates
  `SBO_ASSERT(a_empty_zero, res_valid && !valid_res |-> tile_x == '0 && tile_y == '0, "empty result with nonzero coordinates")

  // the result beat frees the request side
  `SBO_ASSERT(a_ready_after_res, res_valid && res_ready |=> req_ready, "request side not ready after result beat")

endmodule

bind spiral_bucket_order sbo_checker u_sbo_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .valid_res (res.valid_res),
  .tile_x    (res.tile_x),
  .tile_y    (res.tile_y)
);

`default_nettype wire
